@@ src/ffca_pkg.sv @@
`timescale 1ns / 1ps

package ffca_pkg;

   localparam int NUM_CHUNKS_DEFAULT = 64;

   localparam int ADDR_W   = 32;
   localparam int REQ_W    = 24;
   localparam int OFFSET_W = 24;
   localparam int BYTES_W  = 25;
   localparam int HDR_W    = 6;
   localparam int CSR_IDX_W = 2;

   // reset values of the configuration registers
   localparam logic [ADDR_W-1:0]  HEAP_BASE_RESET    = 32'h0000_0000;
   localparam logic [HDR_W-1:0]   HEADER_BYTES_RESET = 6'd16;
   localparam logic [BYTES_W-1:0] HEAP_LIMIT_RESET   = 25'd65536;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_BASE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_BYTES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_LIMIT   = 2'd2;

   // opcodes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EXHAUSTED = 2'd1;
   localparam logic [1:0] ST_TABLE_FULL = 2'd2;
   localparam logic [1:0] ST_UNKNOWN   = 2'd3;

   // largest offset span of the heap
   localparam logic [BYTES_W-1:0] OFFSET_SPAN = 25'h100_0000;

   typedef struct packed {
      logic              opcode;
      logic [REQ_W-1:0]  request_bytes;
      logic [ADDR_W-1:0] free_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] payload_address;
      logic [1:0]        status;
   } rsp_type;

   typedef struct packed {
      logic                is_free;
      logic [BYTES_W-1:0]  chunk_bytes;
      logic [OFFSET_W-1:0] chunk_offset;
   } entry_type;

   typedef struct packed {
      logic hit;
      logic seen;
   } match_type;

endpackage

@@ src/ffca_table.sv @@
`timescale 1ns / 1ps

module ffca_table #(
   parameter int NUM_CHUNKS = ffca_pkg::NUM_CHUNKS_DEFAULT,
   localparam int IW = $clog2(NUM_CHUNKS)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IW-1:0]       wr_addr,
   input  ffca_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [IW-1:0]       rd_addr,
   output ffca_pkg::entry_type rd_data
);

   ffca_pkg::entry_type mem_ff [NUM_CHUNKS];
   ffca_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/ffca_match.sv @@
`timescale 1ns / 1ps

module ffca_match (
   input  logic                              opcode,
   input  logic [ffca_pkg::BYTES_W-1:0]      total,
   input  logic [ffca_pkg::ADDR_W-1:0]       key,
   input  ffca_pkg::entry_type               entry,
   output ffca_pkg::match_type               result
);

   logic addr_match;

   // key is free_address - base - header, so a match needs the top byte clear
   assign addr_match = (key[ffca_pkg::ADDR_W-1:ffca_pkg::OFFSET_W] == '0) &&
                       (key[ffca_pkg::OFFSET_W-1:0] == entry.chunk_offset);

   always_comb begin
      if (opcode == ffca_pkg::OP_FREE) begin
         result.hit  = addr_match && !entry.is_free;
         result.seen = addr_match;
      end else begin
         result.hit  = entry.is_free && (entry.chunk_bytes >= total);
         result.seen = 1'b0;
      end
   end

endmodule

@@ src/first_fit_chunk_allocator.sv @@
`timescale 1ns / 1ps

// channel   | ports                                   | transfer when
// ----------+-----------------------------------------+--------------------------
// request   | start, busy, req_data                   | start high, busy low
// response  | rsp_valid, rsp_data                     | rsp_valid high (1 cycle)
// config    | csr_valid, csr_ready, csr_index, csr_data | csr_valid and csr_ready
//
// a request walks the chunk table one entry per cycle through the single
// table read port and the compare unit, and ends early when an entry hits.
// busy stays high from the request until the response strobe; the response
// is shown for one cycle and cannot be stalled.
// reset is synchronous; table contents need no clearing since only entries
// below the chunk count are ever read.

module first_fit_chunk_allocator #(
   parameter int NUM_CHUNKS = ffca_pkg::NUM_CHUNKS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  ffca_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   output ffca_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ffca_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ffca_pkg::ADDR_W-1:0]         csr_data
);

   localparam int IW = $clog2(NUM_CHUNKS);
   localparam int CW = $clog2(NUM_CHUNKS + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_MISS = 2'd2;

   logic [1:0]                       state_ff, state_in;
   logic                             op_ff, op_in;
   logic [ffca_pkg::BYTES_W-1:0]     total_ff, total_in;
   logic [ffca_pkg::ADDR_W-1:0]      key_ff, key_in;
   logic [CW-1:0]                    rd_idx_ff, rd_idx_in;
   logic                             pend_ff, pend_in;
   logic [IW-1:0]                    eval_idx_ff, eval_idx_in;
   logic                             seen_ff, seen_in;
   logic [CW-1:0]                    count_ff, count_in;
   logic [ffca_pkg::BYTES_W-1:0]     heap_end_ff, heap_end_in;
   logic [ffca_pkg::ADDR_W-1:0]      base_ff;
   logic [ffca_pkg::HDR_W-1:0]       header_ff;
   logic [ffca_pkg::BYTES_W-1:0]     limit_ff;
   logic                             rsp_valid_ff, rsp_valid_in;
   ffca_pkg::rsp_type                rsp_data_ff, rsp_data_in;

   logic                             wr_en;
   logic [IW-1:0]                    wr_addr;
   ffca_pkg::entry_type              wr_data;
   logic                             rd_en;
   ffca_pkg::entry_type              rd_data;
   ffca_pkg::match_type              mres;

   logic                             issue;
   logic                             last_entry;
   logic [ffca_pkg::BYTES_W-1:0]     limit_eff;
   logic [ffca_pkg::BYTES_W:0]       grow_sum;
   logic                             exhausted;
   logic [ffca_pkg::OFFSET_W-1:0]    pay_off;
   logic [ffca_pkg::ADDR_W-1:0]      payload_sum;

   ffca_table #(
      .NUM_CHUNKS(NUM_CHUNKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[IW-1:0]),
      .rd_data (rd_data)
   );

   ffca_match u_match (
      .opcode (op_ff),
      .total  (total_ff),
      .key    (key_ff),
      .entry  (rd_data),
      .result (mres)
   );

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign issue      = (rd_idx_ff < count_ff);
   assign last_entry = ((CW'(eval_idx_ff) + CW'(1)) == count_ff);

   assign limit_eff = (limit_ff > ffca_pkg::OFFSET_SPAN) ? ffca_pkg::OFFSET_SPAN : limit_ff;
   assign grow_sum  = {1'b0, heap_end_ff} + {1'b0, total_ff};
   assign exhausted = (heap_end_ff >= ffca_pkg::OFFSET_SPAN) ||
                      (grow_sum > {1'b0, limit_eff});

   // one adder serves both the hit and the append address
   assign pay_off     = (state_ff == S_MISS) ? heap_end_ff[ffca_pkg::OFFSET_W-1:0]
                                             : rd_data.chunk_offset;
   assign payload_sum = base_ff + ffca_pkg::ADDR_W'(pay_off) +
                        ffca_pkg::ADDR_W'(header_ff);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      total_in     = total_ff;
      key_in       = key_ff;
      rd_idx_in    = rd_idx_ff;
      pend_in      = pend_ff;
      eval_idx_in  = eval_idx_ff;
      seen_in      = seen_ff;
      count_in     = count_ff;
      heap_end_in  = heap_end_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_en        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in     = req_data.opcode;
               total_in  = ffca_pkg::BYTES_W'(req_data.request_bytes) +
                           ffca_pkg::BYTES_W'(header_ff);
               key_in    = req_data.free_address - base_ff -
                           ffca_pkg::ADDR_W'(header_ff);
               rd_idx_in = '0;
               pend_in   = 1'b0;
               seen_in   = 1'b0;
               state_in  = (count_ff == '0) ? S_MISS : S_SCAN;
            end
         end

         S_SCAN: begin
            // read of the next entry overlaps the compare of the previous one
            rd_en       = issue;
            pend_in     = issue;
            eval_idx_in = rd_idx_ff[IW-1:0];
            rd_idx_in   = rd_idx_ff + CW'(issue);
            if (pend_ff) begin
               if (mres.seen) begin
                  seen_in = 1'b1;
               end
               if (mres.hit) begin
                  wr_en           = 1'b1;
                  wr_addr         = eval_idx_ff;
                  wr_data         = rd_data;
                  wr_data.is_free = (op_ff == ffca_pkg::OP_FREE);
                  rsp_valid_in    = 1'b1;
                  rsp_data_in.status = ffca_pkg::ST_OK;
                  rsp_data_in.payload_address =
                     (op_ff == ffca_pkg::OP_ALLOC) ? payload_sum : '0;
                  state_in        = S_IDLE;
               end else if (last_entry) begin
                  state_in = S_MISS;
               end
            end
         end

         S_MISS: begin
            rsp_valid_in = 1'b1;
            rsp_data_in.payload_address = '0;
            state_in = S_IDLE;
            if (op_ff == ffca_pkg::OP_FREE) begin
               rsp_data_in.status = seen_ff ? ffca_pkg::ST_OK : ffca_pkg::ST_UNKNOWN;
            end else if (exhausted) begin
               rsp_data_in.status = ffca_pkg::ST_EXHAUSTED;
            end else if (count_ff == CW'(NUM_CHUNKS)) begin
               rsp_data_in.status = ffca_pkg::ST_TABLE_FULL;
            end else begin
               // append a new chunk at the heap end
               wr_en                = 1'b1;
               wr_addr              = count_ff[IW-1:0];
               wr_data.is_free      = 1'b0;
               wr_data.chunk_bytes  = total_ff;
               wr_data.chunk_offset = heap_end_ff[ffca_pkg::OFFSET_W-1:0];
               count_in             = count_ff + CW'(1);
               heap_end_in          = grow_sum[ffca_pkg::BYTES_W-1:0];
               rsp_data_in.status   = ffca_pkg::ST_OK;
               rsp_data_in.payload_address = payload_sum;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         heap_end_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         heap_end_ff  <= heap_end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      total_ff    <= total_in;
      key_ff      <= key_in;
      rd_idx_ff   <= rd_idx_in;
      eval_idx_ff <= eval_idx_in;
      seen_ff     <= seen_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= ffca_pkg::HEAP_BASE_RESET;
         header_ff <= ffca_pkg::HEADER_BYTES_RESET;
         limit_ff  <= ffca_pkg::HEAP_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ffca_pkg::CSR_HEAP_BASE: begin
               base_ff <= csr_data;
            end
            ffca_pkg::CSR_HEADER_BYTES: begin
               header_ff <= csr_data[ffca_pkg::HDR_W-1:0];
            end
            ffca_pkg::CSR_HEAP_LIMIT: begin
               limit_ff <= csr_data[ffca_pkg::BYTES_W-1:0];
            end
            default: begin
               // unused index, transfer ignored
            end
         endcase
      end
   end

endmodule
